// File: rtl/dq_pkg.sv
// dq_pkg: opcode codes and the request records passed between the
// double-ended queue front end, back end and its result queue.
// No dependencies.
package dq_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd4;
  localparam logic [2:0] OP_POP_BACK   = 3'd5;

  localparam int DATA_W  = 16;
  localparam int OCC_W   = 11;
  localparam int Q_DEPTH = 4;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // decoded request
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              peek;
    logic              at_front;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // executed request, waiting for read data
  typedef struct packed {
    logic             peek_hit;
    logic             was_empty;
    logic             push_dropped;
    logic [OCC_W-1:0] occupancy;
  } exec_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              was_empty;
    logic              push_dropped;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

endpackage

// File: rtl/double_ended_queue_top.sv
// double_ended_queue_top: bounded double-ended queue on a circular buffer.
// Depends on dq_pkg, dq_front, dq_back.
//
//   channel  direction  handshake      payload
//   request  in         push / full    opcode, push_value
//   result   out        pop / empty    read_value, was_empty, push_dropped, occupancy
//
// Sustains one request per cycle while the back end is not stalled; a result
// becomes visible after the request queue, the registered RAM read and the result queue.
// full rises when the 4-entry request queue fills; the back end stalls when
// the 4-entry result queue and the RAM read stage have no room.
// rst clears head, count and both queues; entry storage is not cleared.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int WORD_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] push_value,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] read_value,
  output logic              was_empty,
  output logic              push_dropped,
  output logic [OCC_W-1:0]  occupancy
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  dq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  dq_back #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .read_value   (read_value),
    .was_empty    (was_empty),
    .push_dropped (push_dropped),
    .occupancy    (occupancy)
  );

endmodule

// File: rtl/dq_ram.sv
// dq_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dq_fifo.sv
// dq_fifo: small register FIFO with occupancy count.
// No dependencies.
module dq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/dq_front.sv
// dq_front: takes requests, decodes the opcode into a request record and
// queues it for the back end. Depends on dq_pkg, dq_fifo.
module dq_front
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] push_value,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t dec;
  logic cmd_empty;

  always_comb begin
    dec          = '0;
    dec.value    = push_value;
    case (opcode)
      OP_PUSH_BACK: begin
        dec.push = 1'b1;
      end
      OP_PUSH_FRONT: begin
        dec.push     = 1'b1;
        dec.at_front = 1'b1;
      end
      OP_PEEK_FRONT: begin
        dec.peek     = 1'b1;
        dec.at_front = 1'b1;
      end
      OP_POP_FRONT: begin
        dec.pop      = 1'b1;
        dec.at_front = 1'b1;
      end
      OP_PEEK_BACK: begin
        dec.peek = 1'b1;
      end
      OP_POP_BACK: begin
        dec.pop = 1'b1;
      end
      default: begin
        dec.push = 1'b0;
      end
    endcase
  end

  dq_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (dec),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty),
    .count   ()
  );

  assign cmd_valid = !cmd_empty;

endmodule

// File: rtl/dq_back.sv
// dq_back: executes queued requests against head pointer, entry count and
// the entry RAM; results go to an output queue. Depends on dq_pkg, dq_ram,
// dq_fifo.
module dq_back
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int WORD_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] read_value,
  output logic              was_empty,
  output logic              push_dropped,
  output logic [OCC_W-1:0]  occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              issue;
  logic              q_empty;
  logic              q_full;
  logic [SW-1:0]     sum;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     last;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic              is_empty;
  logic              is_full;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [WORD_WIDTH-1:0] rdata;
  exec_t             ex;
  exec_t             s1;
  logic              s1_valid;
  res_t              res_in;
  res_t              res_out;
  logic [QCNT_W-1:0] q_count;

  // credit: room in the result queue for everything in flight
  assign issue   = cmd_valid &&
                   ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid) < (QCNT_W + 1)'(Q_DEPTH));
  assign cmd_pop = issue;

  assign is_empty = (count == '0);
  assign is_full  = (count == CAP_C);
  assign sum      = SW'(head) + SW'(count);
  assign tail     = (sum >= CAP_S) ? AW'(sum - CAP_S) : AW'(sum);
  assign last     = (tail == '0) ? LAST_IDX : tail - AW'(1);
  assign head_dec = (head == '0) ? LAST_IDX : head - AW'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign wdata    = WORD_WIDTH'(64'(cmd.value));
  assign raddr    = cmd.at_front ? head : last;

  always_comb begin
    head_next       = head;
    count_next      = count;
    we              = 1'b0;
    waddr           = tail;
    ex.peek_hit     = cmd.peek && !is_empty;
    ex.was_empty    = is_empty;
    ex.push_dropped = cmd.push && is_full;
    if (cmd.push && !is_full) begin
      we         = 1'b1;
      count_next = count + CW'(1);
      if (cmd.at_front) begin
        head_next = head_dec;
        waddr     = head_dec;
      end
    end
    if (cmd.pop && !is_empty) begin
      count_next = count - CW'(1);
      if (cmd.at_front) begin
        head_next = head_inc;
      end
    end
    ex.occupancy = OCC_W'(32'(count_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= ex;
    end
  end

  dq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (issue && we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res_in.read_value   = s1.peek_hit ? DATA_W'(64'(rdata)) : '0;
    res_in.was_empty    = s1.was_empty;
    res_in.push_dropped = s1.push_dropped;
    res_in.occupancy    = s1.occupancy;
  end

  dq_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_valid),
    .wr_data (res_in),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (q_empty),
    .count   (q_count)
  );

  assign empty        = q_empty;
  assign read_value   = res_out.read_value;
  assign was_empty    = res_out.was_empty;
  assign push_dropped = res_out.push_dropped;
  assign occupancy    = res_out.occupancy;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX) else $error("head pointer out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !q_full) else $error("result lost: result queue full");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    issue && ex.push_dropped |=> count == $past(count) && head == $past(head))
    else $error("dropped push changed state");

  a_peek_not_empty: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.peek_hit && s1.was_empty)) else $error("peek hit on empty queue");
`endif

endmodule

// File: test/dq_checker.sv
`timescale 1ns / 100ps
// dq_checker: watches the request and result channels of the double-ended queue,
// keeps its own deque image and compares each result against the oldest prediction.
// Depends on dq_pkg.
module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] push_value,
  input  logic              empty,
  input  logic              pop,
  input  logic [DATA_W-1:0] read_value,
  input  logic              was_empty,
  input  logic              push_dropped,
  input  logic [OCC_W-1:0]  occupancy,
  output int                fail_count,
  output int                results_pending
);

  logic [DATA_W-1:0] words [DEPTH];
  int unsigned       front_idx;
  int unsigned       fill;
  res_t              predicted_q [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    front_idx       = 0;
    fill            = 0;
  end

  function automatic res_t apply_request(logic [2:0] op, logic [DATA_W-1:0] val);
    res_t r;
    logic was_e;
    logic at_cap;
    r      = '0;
    was_e  = (fill == 0);
    at_cap = (fill >= DEPTH);
    r.was_empty = was_e;
    case (op)
      OP_PUSH_BACK: begin
        if (at_cap) begin
          r.push_dropped = 1'b1;
        end else begin
          words[(front_idx + fill) % DEPTH] = val;
          fill++;
        end
      end
      OP_PUSH_FRONT: begin
        if (at_cap) begin
          r.push_dropped = 1'b1;
        end else begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          words[front_idx] = val;
          fill++;
        end
      end
      OP_PEEK_FRONT: begin
        if (!was_e) r.read_value = words[front_idx];
      end
      OP_POP_FRONT: begin
        if (!was_e) begin
          front_idx = (front_idx + 1) % DEPTH;
          fill--;
        end
      end
      OP_PEEK_BACK: begin
        if (!was_e) r.read_value = words[(front_idx + fill - 1) % DEPTH];
      end
      OP_POP_BACK: begin
        if (!was_e) fill--;
      end
      default: begin
      end
    endcase
    r.occupancy = fill[OCC_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      front_idx = 0;
      fill      = 0;
      predicted_q.delete();
    end else begin
      if (pop && !empty) begin
        if (predicted_q.size() == 0) begin
          $error("result popped with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_q[0];
          predicted_q.delete(0);
          check_field("read_value", 64'(want.read_value), 64'(read_value));
          check_field("was_empty", 64'(want.was_empty), 64'(was_empty));
          check_field("push_dropped", 64'(want.push_dropped), 64'(push_dropped));
          check_field("occupancy", 64'(want.occupancy), 64'(occupancy));
        end
      end
      if (push && !full) predicted_q = {predicted_q, apply_request(opcode, push_value)};
    end
    results_pending = predicted_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// tb: request stimulus, result draining and verdict for double_ended_queue_top.
// Depends on dq_pkg, double_ended_queue_top and dq_checker.
module tb;
  import dq_pkg::*;

  localparam int          DEPTH          = 1024;
  localparam int          STALL_LIMIT    = 2000;
  localparam int          RX_HOLD_CYCLES = 200;
  localparam logic [2:0]  OP_RSVD6       = 3'd6;
  localparam logic [2:0]  OP_RSVD7       = 3'd7;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [2:0]        opcode;
  logic [DATA_W-1:0] push_value;
  logic              empty;
  logic              pop;
  logic [DATA_W-1:0] read_value;
  logic              was_empty;
  logic              push_dropped;
  logic [OCC_W-1:0]  occupancy;
  int                fail_count;
  int                results_pending;
  int                tx_run;
  int                rx_run;
  int                idle_cycles;
  logic              rx_hold;

  double_ended_queue_top #(
    .CAPACITY  (DEPTH),
    .WORD_WIDTH(DATA_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .push_value  (push_value),
    .empty       (empty),
    .pop         (pop),
    .read_value  (read_value),
    .was_empty   (was_empty),
    .push_dropped(push_dropped),
    .occupancy   (occupancy)
  );

  dq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .push_value     (push_value),
    .empty          (empty),
    .pop            (pop),
    .read_value     (read_value),
    .was_empty      (was_empty),
    .push_dropped   (push_dropped),
    .occupancy      (occupancy),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // zero-gap stretches mixed with random gaps
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run_left = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [2:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    case ($urandom_range(0, 3))
      0: return OP_PEEK_FRONT;
      1: return OP_PEEK_BACK;
      2: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic [DATA_W-1:0] val);
    int gap;
    gap = draw_gap(tx_run);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    opcode     <= op;
    push_value <= val;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic run_phase(int n, int push_pct, int pop_pct);
    repeat (n) send_request(pick_op(push_pct, pop_pct), DATA_W'($urandom));
  endtask

  task automatic settle();
    push <= 1'b0;
    wait (results_pending == 0);
    @(negedge clk);
  endtask

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      gap = draw_gap(rx_run);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    opcode     = OP_PUSH_BACK;
    push_value = '0;
    tx_run     = 0;
    rx_run     = 0;
    rx_hold    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty-queue corners
    send_request(OP_PEEK_FRONT, 16'hFFFF);
    send_request(OP_PEEK_BACK, 16'h0000);
    send_request(OP_POP_FRONT, 16'hFFFF);
    send_request(OP_POP_BACK, 16'h1234);
    send_request(OP_RSVD6, 16'hFFFF);
    send_request(OP_RSVD7, 16'h0000);
    // front push from head zero wraps the pointer
    send_request(OP_PUSH_BACK, 16'h0000);
    send_request(OP_PUSH_BACK, 16'hFFFF);
    send_request(OP_PUSH_FRONT, 16'hA5A5);
    send_request(OP_PUSH_FRONT, 16'h5A5A);
    send_request(OP_PEEK_FRONT, 16'hFFFF);
    send_request(OP_PEEK_BACK, 16'hFFFF);
    send_request(OP_RSVD7, 16'hFFFF);
    send_request(OP_POP_FRONT, 16'h0000);
    send_request(OP_PEEK_FRONT, 16'h0000);
    send_request(OP_POP_BACK, 16'h0000);
    send_request(OP_PEEK_BACK, 16'h0000);
    send_request(OP_POP_BACK, 16'h0000);
    send_request(OP_POP_FRONT, 16'h0000);
    send_request(OP_PEEK_BACK, 16'h0000);
    send_request(OP_RSVD6, 16'h0000);
    settle();

    // result side stalls while requests keep coming
    rx_hold = 1'b1;
    run_phase(150, 35, 35);
    // fill to capacity, then dropped pushes
    run_phase(1100, 97, 0);
    settle();
    run_phase(100, 50, 40);
    // drain a large part of the stored words
    run_phase(450, 0, 96);
    settle();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
